// ===== hdl/dfr_pkg.sv =====
package dfr_pkg;

	localparam logic [47:0] KEY_RESET = 48'h1234_5678_9ABC;

	localparam logic [4:0] EXPAND_MAP [0:47] = '{
		5'd31, 5'd0,  5'd1,  5'd2,  5'd3,  5'd4,  5'd3,  5'd4,
		5'd5,  5'd6,  5'd7,  5'd8,  5'd7,  5'd8,  5'd9,  5'd10,
		5'd11, 5'd12, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16,
		5'd15, 5'd16, 5'd17, 5'd18, 5'd19, 5'd20, 5'd19, 5'd20,
		5'd21, 5'd22, 5'd23, 5'd24, 5'd23, 5'd24, 5'd25, 5'd26,
		5'd27, 5'd28, 5'd27, 5'd28, 5'd29, 5'd30, 5'd31, 5'd0
	};

	localparam logic [4:0] PERM_MAP [0:31] = '{
		5'd15, 5'd6,  5'd19, 5'd20, 5'd28, 5'd11, 5'd27, 5'd16,
		5'd0,  5'd14, 5'd22, 5'd25, 5'd4,  5'd17, 5'd30, 5'd9,
		5'd1,  5'd7,  5'd23, 5'd13, 5'd31, 5'd26, 5'd2,  5'd8,
		5'd18, 5'd12, 5'd29, 5'd5,  5'd21, 5'd10, 5'd3,  5'd24
	};

	localparam logic [3:0] SBOX [0:7][0:63] = '{
		'{4'd14, 4'd0,  4'd4,  4'd15, 4'd13, 4'd7,  4'd1,  4'd4,
		  4'd2,  4'd14, 4'd15, 4'd2,  4'd11, 4'd13, 4'd8,  4'd1,
		  4'd3,  4'd10, 4'd10, 4'd6,  4'd6,  4'd12, 4'd12, 4'd11,
		  4'd5,  4'd9,  4'd9,  4'd5,  4'd0,  4'd3,  4'd7,  4'd8,
		  4'd4,  4'd15, 4'd1,  4'd12, 4'd14, 4'd8,  4'd8,  4'd2,
		  4'd13, 4'd4,  4'd6,  4'd9,  4'd2,  4'd1,  4'd11, 4'd7,
		  4'd15, 4'd5,  4'd12, 4'd11, 4'd9,  4'd3,  4'd7,  4'd14,
		  4'd3,  4'd10, 4'd10, 4'd0,  4'd5,  4'd6,  4'd0,  4'd13},
		'{4'd15, 4'd3,  4'd1,  4'd13, 4'd8,  4'd4,  4'd14, 4'd7,
		  4'd6,  4'd15, 4'd11, 4'd2,  4'd3,  4'd8,  4'd4,  4'd14,
		  4'd9,  4'd12, 4'd7,  4'd0,  4'd2,  4'd1,  4'd13, 4'd10,
		  4'd12, 4'd6,  4'd0,  4'd9,  4'd5,  4'd11, 4'd10, 4'd5,
		  4'd0,  4'd13, 4'd14, 4'd8,  4'd7,  4'd10, 4'd11, 4'd1,
		  4'd10, 4'd3,  4'd4,  4'd15, 4'd13, 4'd4,  4'd1,  4'd2,
		  4'd5,  4'd11, 4'd8,  4'd6,  4'd12, 4'd7,  4'd6,  4'd12,
		  4'd9,  4'd0,  4'd3,  4'd5,  4'd2,  4'd14, 4'd15, 4'd9},
		'{4'd10, 4'd13, 4'd0,  4'd7,  4'd9,  4'd0,  4'd14, 4'd9,
		  4'd6,  4'd3,  4'd3,  4'd4,  4'd15, 4'd6,  4'd5,  4'd10,
		  4'd1,  4'd2,  4'd13, 4'd8,  4'd12, 4'd5,  4'd7,  4'd14,
		  4'd11, 4'd12, 4'd4,  4'd11, 4'd2,  4'd15, 4'd8,  4'd1,
		  4'd13, 4'd1,  4'd6,  4'd10, 4'd4,  4'd13, 4'd9,  4'd0,
		  4'd8,  4'd6,  4'd15, 4'd9,  4'd3,  4'd8,  4'd0,  4'd7,
		  4'd11, 4'd4,  4'd1,  4'd15, 4'd2,  4'd14, 4'd12, 4'd3,
		  4'd5,  4'd11, 4'd10, 4'd5,  4'd14, 4'd2,  4'd7,  4'd12},
		'{4'd7,  4'd13, 4'd13, 4'd8,  4'd14, 4'd11, 4'd3,  4'd5,
		  4'd0,  4'd6,  4'd6,  4'd15, 4'd9,  4'd0,  4'd10, 4'd3,
		  4'd1,  4'd4,  4'd2,  4'd7,  4'd8,  4'd2,  4'd5,  4'd12,
		  4'd11, 4'd1,  4'd12, 4'd10, 4'd4,  4'd14, 4'd15, 4'd9,
		  4'd10, 4'd3,  4'd6,  4'd15, 4'd9,  4'd0,  4'd0,  4'd6,
		  4'd12, 4'd10, 4'd11, 4'd1,  4'd7,  4'd13, 4'd13, 4'd8,
		  4'd15, 4'd9,  4'd1,  4'd4,  4'd3,  4'd5,  4'd14, 4'd11,
		  4'd5,  4'd12, 4'd2,  4'd7,  4'd8,  4'd2,  4'd4,  4'd14},
		'{4'd2,  4'd14, 4'd12, 4'd11, 4'd4,  4'd2,  4'd1,  4'd12,
		  4'd7,  4'd4,  4'd10, 4'd7,  4'd11, 4'd13, 4'd6,  4'd1,
		  4'd8,  4'd5,  4'd5,  4'd0,  4'd3,  4'd15, 4'd15, 4'd10,
		  4'd13, 4'd3,  4'd0,  4'd9,  4'd14, 4'd8,  4'd9,  4'd6,
		  4'd4,  4'd11, 4'd2,  4'd8,  4'd1,  4'd12, 4'd11, 4'd7,
		  4'd10, 4'd1,  4'd13, 4'd14, 4'd7,  4'd2,  4'd8,  4'd13,
		  4'd15, 4'd6,  4'd9,  4'd15, 4'd12, 4'd0,  4'd5,  4'd9,
		  4'd6,  4'd10, 4'd3,  4'd4,  4'd0,  4'd5,  4'd14, 4'd3},
		'{4'd12, 4'd10, 4'd1,  4'd15, 4'd10, 4'd4,  4'd15, 4'd2,
		  4'd9,  4'd7,  4'd2,  4'd12, 4'd6,  4'd9,  4'd8,  4'd5,
		  4'd0,  4'd6,  4'd13, 4'd1,  4'd3,  4'd13, 4'd4,  4'd14,
		  4'd14, 4'd0,  4'd7,  4'd11, 4'd5,  4'd3,  4'd11, 4'd8,
		  4'd9,  4'd4,  4'd14, 4'd3,  4'd15, 4'd2,  4'd5,  4'd12,
		  4'd2,  4'd9,  4'd8,  4'd5,  4'd12, 4'd15, 4'd3,  4'd10,
		  4'd7,  4'd11, 4'd0,  4'd14, 4'd4,  4'd1,  4'd10, 4'd7,
		  4'd1,  4'd6,  4'd13, 4'd0,  4'd11, 4'd8,  4'd6,  4'd13},
		'{4'd4,  4'd13, 4'd11, 4'd0,  4'd2,  4'd11, 4'd14, 4'd7,
		  4'd15, 4'd4,  4'd0,  4'd9,  4'd8,  4'd1,  4'd13, 4'd10,
		  4'd3,  4'd14, 4'd12, 4'd3,  4'd9,  4'd5,  4'd7,  4'd12,
		  4'd5,  4'd2,  4'd10, 4'd15, 4'd6,  4'd8,  4'd1,  4'd6,
		  4'd1,  4'd6,  4'd4,  4'd11, 4'd11, 4'd13, 4'd13, 4'd8,
		  4'd12, 4'd1,  4'd3,  4'd4,  4'd7,  4'd10, 4'd14, 4'd7,
		  4'd10, 4'd9,  4'd15, 4'd5,  4'd6,  4'd0,  4'd8,  4'd15,
		  4'd0,  4'd14, 4'd5,  4'd2,  4'd9,  4'd3,  4'd2,  4'd12},
		'{4'd13, 4'd1,  4'd2,  4'd15, 4'd8,  4'd13, 4'd4,  4'd8,
		  4'd6,  4'd10, 4'd15, 4'd3,  4'd11, 4'd7,  4'd1,  4'd4,
		  4'd10, 4'd12, 4'd9,  4'd5,  4'd3,  4'd6,  4'd14, 4'd11,
		  4'd5,  4'd0,  4'd0,  4'd14, 4'd12, 4'd9,  4'd7,  4'd2,
		  4'd7,  4'd2,  4'd11, 4'd1,  4'd4,  4'd14, 4'd1,  4'd7,
		  4'd9,  4'd4,  4'd12, 4'd10, 4'd14, 4'd8,  4'd2,  4'd13,
		  4'd0,  4'd15, 4'd6,  4'd12, 4'd10, 4'd9,  4'd13, 4'd0,
		  4'd15, 4'd3,  4'd3,  4'd5,  4'd5,  4'd6,  4'd8,  4'd11}
	};

	// Bit i of a word counts from the most significant end, so position i of a
	// 32-bit half is value bit 31-i, which for a 5-bit index is its complement.
	function automatic logic [47:0] expand48(input logic [31:0] r);
		logic [47:0] e;
		for (int i = 0; i < 48; i++) begin
			e[47-i] = r[~EXPAND_MAP[i]];
		end
		return e;
	endfunction

	function automatic logic [31:0] substitute(input logic [47:0] x);
		logic [31:0] s;
		for (int i = 0; i < 8; i++) begin
			s[31-4*i -: 4] = SBOX[i][x[47-6*i -: 6]];
		end
		return s;
	endfunction

	function automatic logic [31:0] permute32(input logic [31:0] s);
		logic [31:0] p;
		for (int i = 0; i < 32; i++) begin
			p[31-i] = s[~PERM_MAP[i]];
		end
		return p;
	endfunction

endpackage

// ===== hdl/dfr_in_if.sv =====
interface dfr_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] left_half;
	logic [31:0] right_half;

	modport source (output valid, output left_half, output right_half, input ready);
	modport sink (input valid, input left_half, input right_half, output ready);
endinterface

// ===== hdl/dfr_out_if.sv =====
interface dfr_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] new_left;
	logic [31:0] new_right;

	modport source (output valid, output new_left, output new_right, input ready);
	modport sink (input valid, input new_left, input new_right, output ready);
endinterface

// ===== hdl/des_feistel_round.sv =====
// Channel     Direction  Payload                          Transfer
// block       sink       left_half, right_half (32 each)  valid & ready
// result      source     new_left, new_right (32 each)    valid & ready
// round_key   write      round_key (48)                   round_key_we
//
// A block passes through two registers between its transfer in and its result:
// the input register, then the result register. The S-box lookup and permutation
// sit between the two. One block can be taken every cycle while results drain.
// Reset clears both stage valid bits and loads the round key with its default.
// A stall on the result side fills the result register, then the input register.
module des_feistel_round (
	input  logic        clk,
	input  logic        arst_n,
	dfr_in_if.sink      block,
	dfr_out_if.source   result,
	input  logic        round_key_we,
	input  logic [47:0] round_key
);

	logic [47:0] key_q;
	logic        valid_s1;
	logic [31:0] left_s1;
	logic [31:0] right_s1;
	logic        valid_s2;
	logic [31:0] new_left_s2;
	logic [31:0] new_right_s2;
	logic        load_s2;
	logic        load_s1;
	logic [31:0] f_out;

	assign load_s2 = !valid_s2 || result.ready;
	assign load_s1 = !valid_s1 || load_s2;
	assign block.ready = load_s1;

	assign f_out = dfr_pkg::permute32(dfr_pkg::substitute(
		dfr_pkg::expand48(right_s1) ^ key_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= dfr_pkg::KEY_RESET;
		end else if (round_key_we) begin
			key_q <= round_key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= block.valid;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && block.valid) begin
			left_s1  <= block.left_half;
			right_s1 <= block.right_half;
		end
		if (load_s2 && valid_s1) begin
			new_left_s2  <= right_s1;
			new_right_s2 <= left_s1 ^ f_out;
		end
	end

	assign result.valid     = valid_s2;
	assign result.new_left  = new_left_s2;
	assign result.new_right = new_right_s2;

	a_stage_advance: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && load_s2 |=> valid_s2)
		else $error("Occupied input stage did not move into the result register.");

	a_left_copy: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && load_s2 |=> new_left_s2 == $past(right_s1))
		else $error("New left half does not match the old right half.");

	a_key_write: assert property (@(posedge clk) disable iff (!arst_n)
		round_key_we |=> key_q == $past(round_key))
		else $error("Round key register did not take the written value.");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> block.ready)
		else $error("Input stage is empty but refuses a transfer.");

endmodule
